// File: sv/phfs_pkg.sv
// ----------------------------------------------------------------------------
// phfs_pkg
// shared types, constants and a lookup function for the header field splitter
// ----------------------------------------------------------------------------
package phfs_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // configuration register indexes
   localparam logic CSR_SKIP_EMPTY   = 1'b0;
   localparam logic CSR_LENGTH_LIMIT = 1'b1;

   localparam logic [31:0] LENGTH_LIMIT_RESET = 32'd104857600;
   localparam logic [31:0] HDR_END            = 32'd12;
   localparam logic [31:0] TRAILER_BYTES      = 32'd8;
   localparam int          QUEUE_DEPTH        = 4;

   localparam logic [7:0] MAGIC_SEQ [4] = '{8'h24, 8'h04, 8'hFF, 8'h00};
   localparam logic [7:0] DELIM_SEQ [5] = '{8'h7C, 8'h1E, 8'h1E, 8'h1F, 8'h7C};

   // one accepted byte's worth of work for the back end
   typedef struct packed {
      logic [39:0] bytes;       // field bytes, first one in the low byte
      logic [2:0]  nbytes;
      logic        end_en;
      logic        end_empty;
      logic        sum_en;
      logic        hdr_valid;
      logic        hdr_complete;
      logic [31:0] length;
      logic [31:0] command;
      logic        cmd_known;
   } desc_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  field_byte;
      logic        field_empty;
      logic        header_valid;
      logic        header_complete;
      logic [31:0] payload_length;
      logic [31:0] command_code;
      logic        command_known;
      logic        final_result;
   } result_type;

   // command whitelist
   function automatic logic cmd_known(input logic [31:0] c);
      logic k;
      unique case (c)
         32'h01, 32'h03, 32'h05, 32'h06, 32'h08, 32'h0D, 32'h0E, 32'h0F,
         32'h10, 32'h11, 32'h13, 32'h18, 32'h1B, 32'h1D, 32'h21, 32'h22,
         32'h23, 32'h24, 32'h26, 32'h27, 32'h2C, 32'h2F, 32'h28, 32'h2E,
         32'h30, 32'h32, 32'h34, 32'h44, 32'h4B, 32'h4C, 32'h4D, 32'h68,
         32'h92, 32'h95, 32'h96, 32'h98, 32'hA3, 32'hB2, 32'hB3, 32'h8F: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

endpackage

// File: sv/phfs_if.sv
// ----------------------------------------------------------------------------
// phfs channel interfaces
// byte input, result output and register write channels
// ----------------------------------------------------------------------------
interface phfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface phfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  field_byte;
   logic        field_empty;
   logic        header_valid;
   logic        header_complete;
   logic [31:0] payload_length;
   logic [31:0] command_code;
   logic        command_known;
   logic        final_result;
   modport source (output valid, kind, field_byte, field_empty, header_valid,
                   header_complete, payload_length, command_code, command_known,
                   final_result, input ready);
   modport sink   (input valid, kind, field_byte, field_empty, header_valid,
                   header_complete, payload_length, command_code, command_known,
                   final_result, output ready);
endinterface

interface phfs_csr_if;
   logic        valid;
   logic        ready;
   logic        addr;
   logic [31:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// File: sv/c2_packet_header_field_splitter_top.sv
// results pass through the descriptor queue, work register and result register
// throughput: one byte per cycle in while the queue has room, one result
// per cycle out while the output is taken; up to seven results per byte
// the descriptor queue absorbs bursts of multi-result bytes
// reset: synchronous, active high; clears packet state, queue and output valid,
// restores skip_empty to 0 and length_limit to 104857600
// ----------------------------------------------------------------------------
// c2_packet_header_field_splitter_top
// packet header check and payload field splitter on a delimiter sequence
// ----------------------------------------------------------------------------
module c2_packet_header_field_splitter_top import phfs_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   phfs_req_if.sink   req_ch,
   phfs_rsp_if.source rsp_ch,
   phfs_csr_if.sink   csr_ch
);

   // front to queue
   logic     q_push;
   logic     q_full;
   desc_type q_data;

   // queue to back
   logic     q_pop;
   logic     q_empty;
   desc_type q_head;

   // front end: accepts one byte per cycle while the queue has room,
   // captures header words, runs the delimiter window and builds a
   // descriptor listing the results the byte causes
   phfs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_data)
   );

   // descriptors for bytes with at least one result wait here, so the
   // input keeps flowing while the output side stalls
   phfs_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // back end: walks each descriptor, field bytes first, then a field end,
   // then the packet summary, into a registered result transaction
   phfs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// File: sv/phfs_front.sv
// ----------------------------------------------------------------------------
// phfs_front
// header capture, delimiter matching and per-byte work descriptors
// ----------------------------------------------------------------------------
module phfs_front import phfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   phfs_req_if.sink req_ch,
   phfs_csr_if.sink csr_ch,
   input  logic     q_full,
   output logic     q_push,
   output desc_type q_data
);

   logic [31:0] pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] cmd_ff, cmd_in;
   logic [31:0] hold_ff, hold_in;
   logic [2:0]  hcnt_ff, hcnt_in;
   logic        magic_ff, magic_in;
   logic        nonempty_ff, nonempty_in;
   logic        finished_ff, finished_in;
   logic        skip_ff;
   logic [31:0] limit_ff;

   logic        accept;
   logic [7:0]  b;
   logic        in_magic, in_len, in_cmd;
   logic        magic_nx;
   logic [31:0] len_nx, cmd_nx, pos_sat;
   logic [32:0] pay_end;
   logic [39:0] cand, shv;
   logic [2:0]  len_c, s_sel, nbytes;
   logic [4:0]  match_vec;
   logic        pay_step, dmatch, pay_flush, last_flush, flush;
   logic        ne_mid, end_en, end_empty, hv, hc_ok;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !q_full;
   assign csr_ch.ready = 1'b1;
   assign b            = req_ch.data_byte;

   // header region decode and capture
   always_comb begin
      in_magic = (pos_ff[31:2] == 30'd0);
      in_len   = (pos_ff[31:3] == 29'd0) && pos_ff[2];
      in_cmd   = (pos_ff[31:4] == 28'd0) && (pos_ff[3:2] == 2'b10);
      magic_nx = magic_ff && !(in_magic && (b != MAGIC_SEQ[pos_ff[1:0]]));
      len_nx   = len_ff;
      cmd_nx   = cmd_ff;
      if (in_len) begin
         len_nx[{pos_ff[1:0], 3'b000} +: 8] = b;
      end
      if (in_cmd) begin
         cmd_nx[{pos_ff[1:0], 3'b000} +: 8] = b;
      end
      pos_sat = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;
      pay_end = {1'b0, len_ff} + {1'b0, TRAILER_BYTES};
   end

   // candidate window: held bytes then the new byte
   always_comb begin
      len_c = hcnt_ff + 3'd1;
      cand  = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i*8 +: 8] = (3'(i) < hcnt_ff) ? hold_ff[i*8 +: 8] : b;
      end
      cand[39:32] = b;
   end

   // tail of the window that is still a delimiter prefix
   always_comb begin
      for (int s = 0; s < 5; s++) begin
         match_vec[s] = 1'b1;
         for (int j = 0; j < 5; j++) begin
            if ((s + j < 5) && (4'(s + j) < {1'b0, len_c})) begin
               if (cand[(s+j)*8 +: 8] != DELIM_SEQ[j]) begin
                  match_vec[s] = 1'b0;
               end
            end
         end
      end
      s_sel = len_c;
      for (int s = 4; s >= 0; s--) begin
         if ((3'(s) < len_c) && match_vec[s]) begin
            s_sel = 3'(s);
         end
      end
      shv = cand >> {s_sel, 3'b000};
   end

   always_comb begin
      pay_step   = !in_magic && !in_len && !in_cmd && !finished_ff &&
                   ({1'b0, pos_ff} < pay_end) && magic_ff && (len_ff < limit_ff);
      dmatch     = pay_step && (len_c == 3'd5) && match_vec[0];
      pay_flush  = pay_step && (({1'b0, pos_ff} + 33'd1) == pay_end);
      last_flush = req_ch.last_byte && !finished_ff && !pay_flush;
      flush      = pay_flush || last_flush;

      if (dmatch) begin
         nbytes = 3'd0;
      end else if (pay_step) begin
         nbytes = flush ? len_c : s_sel;
      end else begin
         nbytes = flush ? hcnt_ff : 3'd0;
      end
      ne_mid = !dmatch && (nonempty_ff || (nbytes != 3'd0));

      if (dmatch) begin
         end_en    = nonempty_ff || !skip_ff;
         end_empty = !nonempty_ff;
      end else begin
         end_en    = flush && ne_mid;
         end_empty = 1'b0;
      end

      hv    = (pos_sat >= HDR_END) && magic_nx && (len_nx < limit_ff);
      hc_ok = {1'b0, pos_sat} >= ({1'b0, len_nx} + {1'b0, TRAILER_BYTES});
   end

   // next packet state
   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      cmd_in      = cmd_ff;
      magic_in    = magic_ff;
      hold_in     = hold_ff;
      hcnt_in     = hcnt_ff;
      nonempty_in = nonempty_ff;
      finished_in = finished_ff;
      if (accept) begin
         if (req_ch.last_byte) begin
            pos_in      = '0;
            len_in      = '0;
            cmd_in      = '0;
            magic_in    = 1'b1;
            hcnt_in     = '0;
            nonempty_in = 1'b0;
            finished_in = 1'b0;
         end else begin
            pos_in      = pos_sat;
            len_in      = len_nx;
            cmd_in      = cmd_nx;
            magic_in    = magic_nx;
            finished_in = finished_ff || pay_flush;
            if (dmatch || flush) begin
               hcnt_in     = '0;
               nonempty_in = 1'b0;
            end else if (pay_step) begin
               hold_in     = shv[31:0];
               hcnt_in     = len_c - s_sel;
               nonempty_in = ne_mid;
            end
         end
      end
   end

   always_comb begin
      q_data.bytes        = cand;
      q_data.nbytes       = nbytes;
      q_data.end_en       = end_en;
      q_data.end_empty    = end_empty;
      q_data.sum_en       = req_ch.last_byte;
      q_data.hdr_valid    = hv;
      q_data.hdr_complete = hc_ok;
      q_data.length       = len_nx;
      q_data.command      = cmd_nx;
      q_data.cmd_known    = cmd_known(cmd_nx);
      q_push = accept && ((nbytes != 3'd0) || end_en || req_ch.last_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         cmd_ff      <= '0;
         magic_ff    <= 1'b1;
         hcnt_ff     <= '0;
         nonempty_ff <= 1'b0;
         finished_ff <= 1'b0;
         skip_ff     <= 1'b0;
         limit_ff    <= LENGTH_LIMIT_RESET;
      end else begin
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         cmd_ff      <= cmd_in;
         magic_ff    <= magic_in;
         hcnt_ff     <= hcnt_in;
         nonempty_ff <= nonempty_in;
         finished_ff <= finished_in;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.addr)
               CSR_SKIP_EMPTY:   skip_ff  <= csr_ch.wdata[0];
               CSR_LENGTH_LIMIT: limit_ff <= csr_ch.wdata;
               default:          skip_ff  <= skip_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

`ifndef SYNTH
   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= 3'd4)
      else $error("hold window count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.last_byte) |=> (pos_ff == '0 && hcnt_ff == '0 && !finished_ff))
      else $error("packet state not cleared after last byte");
`endif

endmodule

// File: sv/phfs_queue.sv
// ----------------------------------------------------------------------------
// phfs_queue
// short descriptor queue between front and back end
// ----------------------------------------------------------------------------
module phfs_queue import phfs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output desc_type head,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("descriptor queue underflow");
`endif

endmodule

// File: sv/phfs_back.sv
// ----------------------------------------------------------------------------
// phfs_back
// expands descriptors into result transactions, one per cycle while the output is taken
// ----------------------------------------------------------------------------
module phfs_back import phfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  desc_type   q_head,
   output logic       q_pop,
   phfs_rsp_if.source rsp_ch
);

   desc_type   work_ff, work_in, work_nx;
   logic       work_vld_ff, work_vld_in;
   result_type rsp_ff, rsp_in, res;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       out_load, emit, remain, work_free;

   assign out_load = !rsp_vld_ff || rsp_ch.ready;
   assign emit     = work_vld_ff && out_load;

   // next result of the current descriptor and what is left of it
   always_comb begin
      work_nx = work_ff;
      res     = '0;
      if (work_ff.nbytes != 3'd0) begin
         res.kind        = KIND_BYTE;
         res.field_byte  = work_ff.bytes[7:0];
         work_nx.bytes   = work_ff.bytes >> 8;
         work_nx.nbytes  = work_ff.nbytes - 3'd1;
      end else if (work_ff.end_en) begin
         res.kind        = KIND_END;
         res.field_empty = work_ff.end_empty;
         work_nx.end_en  = 1'b0;
      end else begin
         res.kind            = KIND_SUMMARY;
         res.header_valid    = work_ff.hdr_valid;
         res.header_complete = work_ff.hdr_complete;
         res.payload_length  = work_ff.length;
         res.command_code    = work_ff.command;
         res.command_known   = work_ff.cmd_known;
         res.final_result    = 1'b1;
         work_nx.sum_en      = 1'b0;
      end
      remain = (work_nx.nbytes != 3'd0) || work_nx.end_en || work_nx.sum_en;
   end

   always_comb begin
      work_free   = !work_vld_ff || (out_load && !remain);
      q_pop       = work_free && !q_empty;
      work_vld_in = q_pop || (work_vld_ff && !work_free);
      work_in     = q_pop ? q_head : (emit ? work_nx : work_ff);
      rsp_vld_in  = out_load ? emit : rsp_vld_ff;
      rsp_in      = emit ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         work_vld_ff <= work_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.kind            = rsp_ff.kind;
   assign rsp_ch.field_byte      = rsp_ff.field_byte;
   assign rsp_ch.field_empty     = rsp_ff.field_empty;
   assign rsp_ch.header_valid    = rsp_ff.header_valid;
   assign rsp_ch.header_complete = rsp_ff.header_complete;
   assign rsp_ch.payload_length  = rsp_ff.payload_length;
   assign rsp_ch.command_code    = rsp_ff.command_code;
   assign rsp_ch.command_known   = rsp_ff.command_known;
   assign rsp_ch.final_result    = rsp_ff.final_result;

`ifndef SYNTH
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(work_vld_ff))
      else $error("result issued without a descriptor in work");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the packet header field splitter: a short table of
// hand-made packets, then random packets over several register settings, with
// every result compared against a cycle-free model of the splitter
// ----------------------------------------------------------------------------
module tb_top;
   import phfs_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 90;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 8;
   localparam int NPHASE       = 6;
   localparam int PAYLOAD_CAP  = 8;
   localparam int STALL_PHASE  = 5;

   localparam logic [7:0] HDR_MAGIC [4]   = '{8'h24, 8'h04, 8'hFF, 8'h00};
   localparam logic [7:0] FIELD_DELIM [5] = '{8'h7C, 8'h1E, 8'h1E, 8'h1F, 8'h7C};
   localparam logic [31:0] KNOWN_CMDS [40] = '{
      32'h01, 32'h03, 32'h05, 32'h06, 32'h08, 32'h0D, 32'h0E, 32'h0F,
      32'h10, 32'h11, 32'h13, 32'h18, 32'h1B, 32'h1D, 32'h21, 32'h22,
      32'h23, 32'h24, 32'h26, 32'h27, 32'h2C, 32'h2F, 32'h28, 32'h2E,
      32'h30, 32'h32, 32'h34, 32'h44, 32'h4B, 32'h4C, 32'h4D, 32'h68,
      32'h92, 32'h95, 32'h96, 32'h98, 32'hA3, 32'hB2, 32'hB3, 32'h8F};

   typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_type;

   // register settings per phase: both extremes of each register show up
   localparam bit          PH_SKIP  [NPHASE] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam logic [31:0] PH_LIMIT [NPHASE] = '{32'hFFFF_FFFF, 32'd0, 32'd20,
                                                 LENGTH_LIMIT_RESET, 32'd7, 32'hFFFF_FFFF};
   localparam idle_mode_type PH_MODE [NPHASE] = '{IDLE_SEND_LIGHT, IDLE_SEND_LIGHT,
                                                  IDLE_SEND_HEAVY, IDLE_SEND_HEAVY,
                                                  IDLE_NONE, IDLE_NONE};

   // one row of the directed table
   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
      logic       typed;     // want holds the hand-written result for this row
      result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   phfs_req_if req_bus ();
   phfs_rsp_if rsp_bus ();
   phfs_csr_if csr_bus ();

   c2_packet_header_field_splitter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // splitter model state, same meaning as the block's own packet state
   bit          skip_empty_cfg;
   logic [31:0] length_limit_cfg;
   logic [31:0] byte_pos;
   logic [31:0] len_word;
   logic [31:0] cmd_word;
   bit          magic_ok;
   logic [7:0]  hold_bytes [4];
   int          hold_len;
   bit          field_has_bytes;
   bit          payload_done;
   logic [7:0]  scan_bytes [5];

   result_type   byte_results [$];     // results caused by the byte just accepted
   result_type   field_results_q [$];  // results the block still owes, oldest first
   stim_row_type dir_rows [$];

   // idling and back-pressure control, shared by sender and receiver
   int send_idle_pct;
   int recv_idle_pct;
   int hold_reqs;
   int hold_seen;
   int hold_left;

   int mismatch_count;
   int bytes_sent;
   int packets_sent;
   int results_seen;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic result_type make_result(input logic [1:0] k, input logic [7:0] fb,
                                              input logic fe, input logic hv,
                                              input logic hc, input logic [31:0] pl,
                                              input logic [31:0] cc, input logic ck,
                                              input logic fin);
      result_type r;
      r.kind            = k;
      r.field_byte      = fb;
      r.field_empty     = fe;
      r.header_valid    = hv;
      r.header_complete = hc;
      r.payload_length  = pl;
      r.command_code    = cc;
      r.command_known   = ck;
      r.final_result    = fin;
      return r;
   endfunction

   function automatic stim_row_type plain_row(input logic [7:0] b, input logic l);
      stim_row_type r;
      r.data    = b;
      r.is_last = l;
      r.typed   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic stim_row_type summary_row(input logic [7:0] b, input result_type w);
      stim_row_type r;
      r.data    = b;
      r.is_last = 1'b1;
      r.typed   = 1'b1;
      r.want    = w;
      return r;
   endfunction

   // append to the results of the current byte
   task automatic add_result(input result_type r);
      byte_results.insert(byte_results.size(), r);
   endtask

   // append a row to the directed table
   task automatic add_row(input stim_row_type r);
      dir_rows.insert(dir_rows.size(), r);
   endtask

   // does scan_bytes[start +: n] equal the first n delimiter bytes
   function automatic bit delim_prefix(input int start, input int n);
      for (int k = 0; k < n; k++) begin
         if (scan_bytes[start + k] != FIELD_DELIM[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic start_packet();
      byte_pos        = '0;
      len_word        = '0;
      cmd_word        = '0;
      magic_ok        = 1'b1;
      hold_len        = 0;
      field_has_bytes = 1'b0;
      payload_done    = 1'b0;
      for (int i = 0; i < 4; i++) hold_bytes[i] = 8'h00;
   endtask

   task automatic emit_byte(input logic [7:0] b);
      add_result(make_result(KIND_BYTE, b, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
      field_has_bytes = 1'b1;
   endtask

   // release held bytes and close the field if it got any bytes
   task automatic close_field();
      for (int i = 0; i < hold_len; i++) emit_byte(hold_bytes[i]);
      hold_len = 0;
      if (field_has_bytes) begin
         add_result(make_result(KIND_END, 8'h00, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0));
      end
      field_has_bytes = 1'b0;
   endtask

   // advance the model by one byte, results go to byte_results
   task automatic split_byte(input logic [7:0] b, input logic is_last);
      logic [31:0] p;
      logic [63:0] pay_end;
      logic        hv;
      logic        hc;
      logic        known;
      int          n;
      int          s;
      p       = byte_pos;
      pay_end = 64'(len_word) + 64'd8;
      if (p < 32'd4) begin
         if (b != HDR_MAGIC[p[1:0]]) magic_ok = 1'b0;
      end else if (p < 32'd8) begin
         len_word = len_word | (32'(b) << (8 * (p - 32'd4)));
      end else if (p < 32'd12) begin
         cmd_word = cmd_word | (32'(b) << (8 * (p - 32'd8)));
      end else if (!payload_done && 64'(p) < pay_end && magic_ok &&
                   len_word < length_limit_cfg) begin
         n = hold_len + 1;
         for (int i = 0; i < hold_len; i++) scan_bytes[i] = hold_bytes[i];
         scan_bytes[hold_len] = b;
         if (n == 5 && delim_prefix(0, 5)) begin
            // whole delimiter: the field ends, maybe as an empty one
            if (field_has_bytes || !skip_empty_cfg) begin
               add_result(make_result(KIND_END, 8'h00, !field_has_bytes, 1'b0,
                                      1'b0, '0, '0, 1'b0, 1'b0));
            end
            hold_len        = 0;
            field_has_bytes = 1'b0;
         end else begin
            // bytes that can no longer start a delimiter leave the window
            s = 0;
            while (s < n && !delim_prefix(s, n - s)) begin
               emit_byte(scan_bytes[s]);
               s++;
            end
            for (int i = 0; s + i < n; i++) hold_bytes[i] = scan_bytes[s + i];
            hold_len = n - s;
         end
         if (64'(p) + 64'd1 == pay_end) begin
            close_field();
            payload_done = 1'b1;
         end
      end
      if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
      if (is_last) begin
         hv    = byte_pos >= 32'd12 && magic_ok && len_word < length_limit_cfg;
         hc    = 64'(byte_pos) >= 64'(len_word) + 64'd8;
         known = 1'b0;
         foreach (KNOWN_CMDS[i]) if (KNOWN_CMDS[i] == cmd_word) known = 1'b1;
         if (!payload_done) close_field();
         add_result(make_result(KIND_SUMMARY, 8'h00, 1'b0, hv, hc, len_word,
                                cmd_word, known, 1'b1));
         start_packet();
      end
   endtask

   // offer one byte from a falling edge, return at the falling edge after acceptance
   task automatic drive_byte(input logic [7:0] b, input logic is_last, input logic typed,
                             input result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= is_last;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      byte_results.delete();
      split_byte(b, is_last);
      if (typed) begin
         byte_results.delete();
         add_result(want);
      end
      foreach (byte_results[i]) begin
         field_results_q.insert(field_results_q.size(), byte_results[i]);
      end
      bytes_sent++;
      if (is_last) packets_sent++;
      @(negedge clock);
   endtask

   // leaves csr valid high, the caller lowers it after its last write
   task automatic write_reg(input logic idx, input logic [31:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      if (idx == CSR_SKIP_EMPTY) skip_empty_cfg = val[0];
      else length_limit_cfg = val;
      @(negedge clock);
   endtask

   // sender stays quiet until the block owes nothing, then through a drain wait
   task automatic wait_drained();
      while (field_results_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic note_diff(input string what, input logic [31:0] want,
                            input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 50) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         end
      end
   endtask

   // result receiver: random ready, plus a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      hold_seen     = 0;
      forever begin
         @(negedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // every accepted result transaction is matched against the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (field_results_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 50) begin
               $display("%0t: unexpected result, expected none, actual kind %0d byte %h",
                        $time, rsp_bus.kind, rsp_bus.field_byte);
            end
         end else begin
            want = field_results_q.pop_front();
            note_diff("kind", 32'(want.kind), 32'(rsp_bus.kind));
            note_diff("field_byte", 32'(want.field_byte), 32'(rsp_bus.field_byte));
            note_diff("field_empty", 32'(want.field_empty), 32'(rsp_bus.field_empty));
            note_diff("header_valid", 32'(want.header_valid), 32'(rsp_bus.header_valid));
            note_diff("header_complete", 32'(want.header_complete),
                      32'(rsp_bus.header_complete));
            note_diff("payload_length", want.payload_length, rsp_bus.payload_length);
            note_diff("command_code", want.command_code, rsp_bus.command_code);
            note_diff("command_known", 32'(want.command_known), 32'(rsp_bus.command_known));
            note_diff("final_result", 32'(want.final_result), 32'(rsp_bus.final_result));
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               field_results_q.size());
      $display("FAILED: results differ");
      $finish;
   end

   // stimulus
   initial begin
      int          start_count;
      int          kind_pick;
      int          plen;
      int          cut;
      int          extra;
      int          idx;
      int          nd;
      int          pick;
      bit          press;
      logic [31:0] lw;
      logic [31:0] cw;
      logic [7:0]  b;
      logic [7:0]  pkt_bytes [$];

      // every block input known from time zero
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.addr      = CSR_SKIP_EMPTY;
      csr_bus.wdata     = '0;
      hold_reqs         = 0;
      mismatch_count    = 0;
      bytes_sent        = 0;
      packets_sent      = 0;
      results_seen      = 0;
      skip_empty_cfg    = 1'b0;
      length_limit_cfg  = LENGTH_LIMIT_RESET;
      start_packet();
      send_idle_pct     = 28;
      recv_idle_pct     = 63;

      // directed table
      // one-byte packet right after reset: nothing captured, summary only
      add_row(summary_row(8'h00, make_result(KIND_SUMMARY, 8'h00, 1'b0, 1'b0,
                          1'b0, 32'h0, 32'h0, 1'b0, 1'b1)));
      // all-ones header: bad magic, both words at their maximum, unknown command
      repeat (11) add_row(plain_row(8'hFF, 1'b0));
      add_row(summary_row(8'hFF, make_result(KIND_SUMMARY, 8'h00, 1'b0, 1'b0,
                          1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1)));
      // good header, length 11, command 1
      foreach (HDR_MAGIC[i]) add_row(plain_row(HDR_MAGIC[i], 1'b0));
      add_row(plain_row(8'h0B, 1'b0));
      repeat (3) add_row(plain_row(8'h00, 1'b0));
      add_row(plain_row(8'h01, 1'b0));
      repeat (3) add_row(plain_row(8'h00, 1'b0));
      // delimiter first (empty field), one byte, then a lone 7C at the payload end
      foreach (FIELD_DELIM[i]) add_row(plain_row(FIELD_DELIM[i], 1'b0));
      add_row(plain_row(8'h41, 1'b0));
      add_row(plain_row(8'h7C, 1'b0));
      // a byte past the payload end, ignored apart from the count
      add_row(plain_row(8'h55, 1'b1));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         drive_byte(dir_rows[i].data, dir_rows[i].is_last, dir_rows[i].typed,
                    dir_rows[i].want);
      end

      // random phases, each behind a fresh pair of register writes
      for (int ph = 0; ph < NPHASE; ph++) begin
         req_bus.valid <= 1'b0;
         wait_drained();
         write_reg(CSR_SKIP_EMPTY, {31'b0, PH_SKIP[ph]});
         write_reg(CSR_LENGTH_LIMIT, PH_LIMIT[ph]);
         csr_bus.valid <= 1'b0;
         case (PH_MODE[ph])
            IDLE_SEND_LIGHT: begin
               send_idle_pct = 28;
               recv_idle_pct = 63;
            end
            IDLE_SEND_HEAVY: begin
               send_idle_pct = 63;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // long receiver stall while bytes keep coming, fills the block
         if (ph == STALL_PHASE) hold_reqs++;

         start_count = bytes_sent;
         while (bytes_sent - start_count < PHASE_BYTES) begin
            // first packet of the stall phase: valid header, full plain payload
            press = (ph == STALL_PHASE) && (bytes_sent == start_count);
            pkt_bytes.delete();
            kind_pick = press ? 99 : int'($urandom_range(99));
            if (kind_pick < 10) begin
               // short noise packet, never reaches the payload
               plen = $urandom_range(1, 11);
               repeat (plen) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(255)));
            end else begin
               if (press) begin
                  lw = 32'd12;
               end else begin
                  case ($urandom_range(7))
                     0:       lw = $urandom;
                     1:       lw = 32'hFFFF_FFFE;
                     2, 3:    lw = $urandom_range(7, 26);
                     default: lw = $urandom_range(0, 10);
                  endcase
               end
               if ($urandom_range(1)) cw = KNOWN_CMDS[$urandom_range(39)];
               else if ($urandom_range(1)) cw = $urandom;
               else cw = $urandom_range(0, 255);
               foreach (HDR_MAGIC[i]) pkt_bytes.insert(pkt_bytes.size(), HDR_MAGIC[i]);
               if (kind_pick < 20) begin
                  // broken magic: one flipped bit
                  idx = $urandom_range(3);
                  pkt_bytes[idx] = pkt_bytes[idx] ^ 8'(1 << $urandom_range(7));
               end
               for (int i = 0; i < 4; i++) pkt_bytes.insert(pkt_bytes.size(), lw[8*i +: 8]);
               for (int i = 0; i < 4; i++) pkt_bytes.insert(pkt_bytes.size(), cw[8*i +: 8]);
               // payload length is L minus the command word, capped for long L
               if (lw < 32'd4) plen = 0;
               else if (lw - 32'd4 > 32'(PAYLOAD_CAP)) plen = PAYLOAD_CAP;
               else plen = int'(lw - 32'd4);
               // payload with whole and partial delimiters mixed in; one may
               // straddle the payload end
               while (pkt_bytes.size() < 12 + plen) begin
                  pick = press ? 9 : int'($urandom_range(9));
                  case (pick)
                     0, 1: begin
                        foreach (FIELD_DELIM[k]) begin
                           pkt_bytes.insert(pkt_bytes.size(), FIELD_DELIM[k]);
                        end
                     end
                     2: begin
                        nd = $urandom_range(1, 4);
                        for (int k = 0; k < nd; k++) begin
                           pkt_bytes.insert(pkt_bytes.size(), FIELD_DELIM[k]);
                        end
                     end
                     3: begin
                        case ($urandom_range(2))
                           0:       b = 8'h7C;
                           1:       b = 8'h1E;
                           default: b = 8'h1F;
                        endcase
                        pkt_bytes.insert(pkt_bytes.size(), b);
                     end
                     default: pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(255)));
                  endcase
               end
               extra = $urandom_range(0, 2);
               repeat (extra) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(255)));
               // some packets end early and are reported incomplete
               if (!press && $urandom_range(99) < 15) begin
                  cut = $urandom_range(1, pkt_bytes.size());
                  while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
               end
            end
            foreach (pkt_bytes[i]) begin
               drive_byte(pkt_bytes[i], (i == pkt_bytes.size() - 1), 1'b0, '0);
            end
         end
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      $display("covered %0d packets, %0d bytes and %0d results", packets_sent, bytes_sent,
               results_seen);
      $display("over %0d register settings with sender and receiver stalls",
               NPHASE + 1);
      if (mismatch_count == 0 && field_results_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
